[hdl/inelastic_disk_collision_top_assert.svh]
// Assertion macros for the checker file
`ifndef INELASTIC_DISK_COLLISION_TOP_ASSERT_SVH
`define INELASTIC_DISK_COLLISION_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset
`define IDC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset
`define IDC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/idc_pkg.sv]
// Types, constants and helpers shared by the disk collision block
package idc_pkg;

    localparam int DW         = 32;
    localparam int REST_W     = 17;
    localparam int REST_SHIFT = 17;
    localparam int MUL_W      = 18;
    localparam int QB         = 43;
    localparam int MAG_W      = 41;
    localparam int DEL_W      = 42;
    localparam int SUM_W      = 43;
    localparam int REM_W      = 114;
    localparam int DIV_W      = 124;
    localparam int Q_DEPTH    = 4;
    localparam int Q_AW       = 2;

    localparam logic [REST_W-1:0] REST_RESET      = 17'h10000;
    localparam logic [MUL_W-1:0]  REST_ONE        = 18'h10000;
    localparam logic [MAG_W-1:0]  DELTA_CAP       = 41'h100_0000_0000;
    localparam logic              REG_RESTITUTION = 1'b0;

    typedef struct packed {
        logic signed [DW-1:0] avx;
        logic signed [DW-1:0] avy;
        logic signed [DW-1:0] bvx;
        logic signed [DW-1:0] bvy;
        logic                 coincident;
    } vel_t;

    typedef struct packed {
        vel_t          vel;
        logic [DW-1:0] cmag_x;
        logic [DW-1:0] cmag_y;
        logic          neg_x;
        logic          neg_y;
        logic [63:0]   s_mag;
        logic [63:0]   dsq;
    } q_item_t;

    typedef struct packed {
        vel_t        vel;
        logic        neg_x;
        logic        neg_y;
        logic [63:0] dsq;
    } back_meta_t;

    function automatic logic signed [DW-1:0] sat32(input logic signed [SUM_W-1:0] v);
        logic [SUM_W-DW:0] top;
        top = v[SUM_W-1:DW-1];
        if (&top || ~|top)
            sat32 = v[DW-1:0];
        else if (v[SUM_W-1])
            sat32 = 32'sh8000_0000;
        else
            sat32 = 32'sh7FFF_FFFF;
    endfunction

endpackage

[hdl/idc_front.sv]
// Front end: differences, dot products and squared distance of each item
module idc_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic signed [31:0]      a_x,
    input  logic signed [31:0]      a_y,
    input  logic signed [31:0]      a_vx,
    input  logic signed [31:0]      a_vy,
    input  logic signed [31:0]      b_x,
    input  logic signed [31:0]      b_y,
    input  logic signed [31:0]      b_vx,
    input  logic signed [31:0]      b_vy,
    input  logic                    q_full,
    output logic                    q_push,
    output idc_pkg::q_item_t        q_item
);
    import idc_pkg::*;

    logic                 fe;
    logic                 f1_v_reg, f2_v_reg, f3_v_reg;
    logic signed [DW-1:0] dx_reg, dy_reg, gx_reg, gy_reg;
    vel_t                 vel1_reg, vel2_reg, vel2_next;
    logic signed [63:0]   t1_reg, t2_reg;
    logic [63:0]          dxx_reg, dyy_reg;
    logic [DW-1:0]        cmag_x_reg, cmag_y_reg;
    logic                 dneg_x_reg, dneg_y_reg;
    logic signed [64:0]   s_sum;
    logic [64:0]          s_abs;
    logic                 s_neg;
    q_item_t              item_reg, item_next;

    // advance unless the last stage is held by a full queue
    assign fe       = !(f3_v_reg && q_full);
    assign in_stall = !fe;
    assign q_push   = f3_v_reg && !q_full;
    assign q_item   = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_v_reg <= 1'b0;
            f2_v_reg <= 1'b0;
            f3_v_reg <= 1'b0;
        end
        else if (fe)
        begin
            f1_v_reg <= in_valid;
            f2_v_reg <= f1_v_reg;
            f3_v_reg <= f2_v_reg;
        end
    end

    always_comb
    begin
        vel2_next            = vel1_reg;
        vel2_next.coincident = (dx_reg == '0) && (dy_reg == '0);
    end

    assign s_sum = 65'(t1_reg) + 65'(t2_reg);
    assign s_neg = s_sum[64];
    assign s_abs = s_neg ? 65'(-s_sum) : 65'(s_sum);

    always_comb
    begin
        item_next.vel    = vel2_reg;
        item_next.cmag_x = cmag_x_reg;
        item_next.cmag_y = cmag_y_reg;
        item_next.neg_x  = dneg_x_reg ^ s_neg;
        item_next.neg_y  = dneg_y_reg ^ s_neg;
        item_next.s_mag  = s_abs[63:0];
        item_next.dsq    = dxx_reg + dyy_reg;
    end

    always_ff @(posedge clk)
    begin
        if (fe)
        begin
            dx_reg         <= sat32(SUM_W'(a_x) - SUM_W'(b_x));
            dy_reg         <= sat32(SUM_W'(a_y) - SUM_W'(b_y));
            gx_reg         <= sat32(SUM_W'(a_vx) - SUM_W'(b_vx));
            gy_reg         <= sat32(SUM_W'(a_vy) - SUM_W'(b_vy));
            vel1_reg.avx   <= a_vx;
            vel1_reg.avy   <= a_vy;
            vel1_reg.bvx   <= b_vx;
            vel1_reg.bvy   <= b_vy;
            vel1_reg.coincident <= 1'b0;

            vel2_reg   <= vel2_next;
            t1_reg     <= gx_reg * dx_reg;
            t2_reg     <= gy_reg * dy_reg;
            dxx_reg    <= dx_reg * dx_reg;
            dyy_reg    <= dy_reg * dy_reg;
            cmag_x_reg <= dx_reg[DW-1] ? DW'(-dx_reg) : DW'(dx_reg);
            cmag_y_reg <= dy_reg[DW-1] ? DW'(-dy_reg) : DW'(dy_reg);
            dneg_x_reg <= dx_reg[DW-1];
            dneg_y_reg <= dy_reg[DW-1];

            item_reg   <= item_next;
        end
    end

endmodule

[hdl/idc_queue.sv]
// Short queue between the front end and the back end
module idc_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  idc_pkg::q_item_t push_item,
    output logic             full,
    input  logic             pop,
    output logic             empty,
    output idc_pkg::q_item_t head
);
    import idc_pkg::*;

    q_item_t         mem_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [Q_AW:0]   count_reg;

    assign full  = (count_reg == (Q_AW+1)'(Q_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule

[hdl/idc_back.sv]
// Back end: impulse numerator, pipelined restoring divider, velocity update
module idc_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_empty,
    input  idc_pkg::q_item_t                  q_head,
    output logic                              q_pop,
    input  logic [idc_pkg::REST_W-1:0]        restitution,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [31:0]                new_a_vx,
    output logic signed [31:0]                new_a_vy,
    output logic signed [31:0]                new_b_vx,
    output logic signed [31:0]                new_b_vy,
    output logic                              coincident
);
    import idc_pkg::*;

    logic             be;
    logic [MUL_W-1:0] mult;

    logic             s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg;
    back_meta_t       s1_m_reg, s2_m_reg, s3_m_reg, s4_m_reg;
    logic [63:0]      plo_reg [2];
    logic [63:0]      phi_reg [2];
    logic [95:0]      prod_reg [2];
    logic [49:0]      pp_reg [2][3];
    logic [REM_W-1:0] num_reg [2];
    back_meta_t       h_meta;

    logic             dv_v_reg [QB];
    back_meta_t       dm_reg [QB];
    logic [REM_W-1:0] rem_reg [QB][2];
    logic [QB-1:0]    quo_reg [QB][2];

    logic                    p_v_reg;
    back_meta_t              p_m_reg;
    logic signed [DEL_W-1:0] delta_reg [2];

    logic                 out_v_reg;
    logic signed [DW-1:0] na_x_reg, na_y_reg, nb_x_reg, nb_y_reg;
    logic                 coin_reg;

    // the whole back end moves whenever the output register can take an item
    assign be    = !out_v_reg || !out_stall;
    assign q_pop = be && !q_empty;
    assign mult  = REST_ONE + MUL_W'(restitution);

    assign h_meta.vel   = q_head.vel;
    assign h_meta.neg_x = q_head.neg_x;
    assign h_meta.neg_y = q_head.neg_y;
    assign h_meta.dsq   = q_head.dsq;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
            s4_v_reg  <= 1'b0;
            p_v_reg   <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (be)
        begin
            s1_v_reg  <= !q_empty;
            s2_v_reg  <= s1_v_reg;
            s3_v_reg  <= s2_v_reg;
            s4_v_reg  <= s3_v_reg;
            p_v_reg   <= dv_v_reg[QB-1];
            out_v_reg <= p_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (be)
        begin
            s1_m_reg   <= h_meta;
            plo_reg[0] <= q_head.cmag_x * q_head.s_mag[31:0];
            phi_reg[0] <= q_head.cmag_x * q_head.s_mag[63:32];
            plo_reg[1] <= q_head.cmag_y * q_head.s_mag[31:0];
            phi_reg[1] <= q_head.cmag_y * q_head.s_mag[63:32];

            s2_m_reg <= s1_m_reg;
            s3_m_reg <= s2_m_reg;
            s4_m_reg <= s3_m_reg;
            for (int l = 0; l < 2; l++)
            begin
                prod_reg[l]  <= 96'(plo_reg[l]) + {phi_reg[l], 32'h0};
                pp_reg[l][0] <= prod_reg[l][31:0] * mult;
                pp_reg[l][1] <= prod_reg[l][63:32] * mult;
                pp_reg[l][2] <= prod_reg[l][95:64] * mult;
                num_reg[l]   <= REM_W'(pp_reg[l][0]) + (REM_W'(pp_reg[l][1]) << 32)
                                + (REM_W'(pp_reg[l][2]) << 64);
            end
        end
    end

    // one quotient bit per stage, top bit first
    for (genvar j = 0; j < QB; j++)
    begin : g_div
        logic             v_in;
        back_meta_t       m_in;
        logic [REM_W-1:0] r_in [2];
        logic [QB-1:0]    q_in [2];

        if (j == 0)
        begin : g_first
            assign v_in    = s4_v_reg;
            assign m_in    = s4_m_reg;
            assign r_in[0] = num_reg[0];
            assign r_in[1] = num_reg[1];
            assign q_in[0] = '0;
            assign q_in[1] = '0;
        end
        else
        begin : g_next
            assign v_in    = dv_v_reg[j-1];
            assign m_in    = dm_reg[j-1];
            assign r_in[0] = rem_reg[j-1][0];
            assign r_in[1] = rem_reg[j-1][1];
            assign q_in[0] = quo_reg[j-1][0];
            assign q_in[1] = quo_reg[j-1][1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_v_reg[j] <= 1'b0;
            else if (be)
                dv_v_reg[j] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (be)
                dm_reg[j] <= m_in;
        end

        for (genvar l = 0; l < 2; l++)
        begin : g_lane
            logic [DIV_W-1:0] den;
            logic             ge;

            assign den = DIV_W'(m_in.dsq) << (REST_SHIFT + QB - 1 - j);
            assign ge  = DIV_W'(r_in[l]) >= den;

            always_ff @(posedge clk)
            begin
                if (be)
                begin
                    rem_reg[j][l] <= ge ? r_in[l] - den[REM_W-1:0] : r_in[l];
                    quo_reg[j][l] <= {q_in[l][QB-2:0], ge};
                end
            end
        end
    end

    // cap the magnitude and attach the sign
    for (genvar l = 0; l < 2; l++)
    begin : g_post
        logic [QB-1:0]    pq;
        logic [MAG_W-1:0] mag;
        logic             neg;

        assign pq  = quo_reg[QB-1][l];
        assign mag = (pq > QB'(DELTA_CAP)) ? DELTA_CAP : pq[MAG_W-1:0];
        assign neg = (l == 0) ? dm_reg[QB-1].neg_x : dm_reg[QB-1].neg_y;

        always_ff @(posedge clk)
        begin
            if (be)
                delta_reg[l] <= neg ? -DEL_W'(mag) : DEL_W'(mag);
        end
    end

    always_ff @(posedge clk)
    begin
        if (be)
        begin
            p_m_reg  <= dm_reg[QB-1];
            coin_reg <= p_m_reg.vel.coincident;
            if (p_m_reg.vel.coincident)
            begin
                na_x_reg <= p_m_reg.vel.avx;
                na_y_reg <= p_m_reg.vel.avy;
                nb_x_reg <= p_m_reg.vel.bvx;
                nb_y_reg <= p_m_reg.vel.bvy;
            end
            else
            begin
                na_x_reg <= sat32(SUM_W'(p_m_reg.vel.avx) - SUM_W'(delta_reg[0]));
                na_y_reg <= sat32(SUM_W'(p_m_reg.vel.avy) - SUM_W'(delta_reg[1]));
                nb_x_reg <= sat32(SUM_W'(p_m_reg.vel.bvx) + SUM_W'(delta_reg[0]));
                nb_y_reg <= sat32(SUM_W'(p_m_reg.vel.bvy) + SUM_W'(delta_reg[1]));
            end
        end
    end

    assign out_valid  = out_v_reg;
    assign new_a_vx   = na_x_reg;
    assign new_a_vy   = na_y_reg;
    assign new_b_vx   = nb_x_reg;
    assign new_b_vy   = nb_y_reg;
    assign coincident = coin_reg;

endmodule

[hdl/inelastic_disk_collision_top.sv]
// Throughput: one item per cycle while out_stall is low; the 43-stage restoring
// divider is fully pipelined, and a four-entry queue parts the front end from the back end.
// Reset (rst_n low, asynchronous) empties every stage and the queue and sets
// restitution to 1.0 (65536); no clearing pass is needed.
module inelastic_disk_collision_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] a_x,
    input  logic signed [31:0] a_y,
    input  logic signed [31:0] a_vx,
    input  logic signed [31:0] a_vy,
    input  logic signed [31:0] b_x,
    input  logic signed [31:0] b_y,
    input  logic signed [31:0] b_vx,
    input  logic signed [31:0] b_vy,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] new_a_vx,
    output logic signed [31:0] new_a_vy,
    output logic signed [31:0] new_b_vx,
    output logic signed [31:0] new_b_vy,
    output logic               coincident
);
    import idc_pkg::*;

    logic [REST_W-1:0] rest_reg;
    logic              q_full, q_empty, q_push, q_pop;
    q_item_t           q_in_item, q_head;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_RESTITUTION) ? 32'(rest_reg) : 32'h0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rest_reg <= REST_RESET;
        else if (psel && penable && pwrite && pready && paddr[2] == REG_RESTITUTION)
            rest_reg <= pwdata[REST_W-1:0];
    end

    idc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .a_x      (a_x),
        .a_y      (a_y),
        .a_vx     (a_vx),
        .a_vy     (a_vy),
        .b_x      (b_x),
        .b_y      (b_y),
        .b_vx     (b_vx),
        .b_vy     (b_vy),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (q_in_item)
    );

    idc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in_item),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    idc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .restitution (rest_reg),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .new_a_vx    (new_a_vx),
        .new_a_vy    (new_a_vy),
        .new_b_vx    (new_b_vx),
        .new_b_vy    (new_b_vy),
        .coincident  (coincident)
    );

endmodule

[hdl/idc_checker.sv]
// Port-level checker for the disk collision block, bound to the top level
`include "inelastic_disk_collision_top_assert.svh"

module idc_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               psel,
    input logic               penable,
    input logic               pwrite,
    input logic [2:0]         paddr,
    input logic [31:0]        pwdata,
    input logic [31:0]        prdata,
    input logic               pready,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [31:0] new_a_vx,
    input logic signed [31:0] new_b_vy,
    input logic               coincident
);

    // a write to restitution reads back its low 17 bits on the next cycle
    `IDC_ASSERT_NEXT(a_rest_readback, psel && penable && pwrite && pready && !paddr[2], paddr[2] || prdata[16:0] == $past(pwdata[16:0]), "restitution readback mismatch")

    `IDC_ASSERT_NOW(a_prdata_upper, 1'b1, prdata[31:17] == 15'h0, "prdata upper bits set")

    `IDC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable({new_a_vx, new_b_vy, coincident}), "stalled item changed")

endmodule

bind inelastic_disk_collision_top idc_checker u_idc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .new_a_vx   (new_a_vx),
    .new_b_vy   (new_b_vy),
    .coincident (coincident)
);
